// ===== rtl/jsu_pkg.sv =====
// Shared types and codes for the JSON string unescaper.
package jsu_pkg;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NO_QUOTE  = 3'd1;
  localparam logic [2:0] ERR_ESCAPE    = 3'd2;
  localparam logic [2:0] ERR_HEX       = 3'd3;
  localparam logic [2:0] ERR_SURROGATE = 3'd4;
  localparam logic [2:0] ERR_CONTROL   = 3'd5;

  localparam int PKT_DEPTH = 4;

  // All results caused by one accepted byte.
  typedef struct packed {
    logic [2:0]      n;
    logic [3:0][7:0] bytes;
    logic [1:0]      kind;
    logic [2:0]      error_code;
    logic [15:0]     decoded_length;
  } jsu_pkt_t;

endpackage

// ===== rtl/jsu_front.sv =====
// Front end: escape/hex/surrogate decoding and UTF-8 encoding, one byte a cycle while take is high.
module jsu_front #(
  parameter int LENGTH_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        in_byte,
  input  logic              begin_req,
  output logic              pkt_valid,
  output jsu_pkg::jsu_pkt_t pkt
);
  import jsu_pkg::*;

  localparam logic [2:0] MODE_NORMAL  = 3'd0;
  localparam logic [2:0] MODE_ESC     = 3'd1;
  localparam logic [2:0] MODE_HEX1    = 3'd2;
  localparam logic [2:0] MODE_WANT_BS = 3'd3;
  localparam logic [2:0] MODE_WANT_U  = 3'd4;
  localparam logic [2:0] MODE_HEX2    = 3'd5;
  localparam logic [2:0] MODE_DONE    = 3'd6;

  logic [2:0]             mode, mode_eff, mode_next;
  logic [1:0]             digits, digits_eff, digits_next;
  logic [15:0]            accum, accum_eff, accum_next;
  logic [9:0]             high, high_eff, high_next;
  logic [LENGTH_BITS-1:0] byte_count, count_eff, count_next;
  logic [LENGTH_BITS:0]   count_sum;
  logic [31:0]            count_wide;
  logic [15:0]            code;
  logic [4:0]             hex;
  logic                   enc;
  logic [20:0]            cp;
  jsu_pkt_t               p;

  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
    else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
    return r;
  endfunction

  always_comb begin
    mode_eff   = begin_req ? MODE_NORMAL : mode;
    digits_eff = begin_req ? 2'd0 : digits;
    accum_eff  = begin_req ? 16'd0 : accum;
    high_eff   = begin_req ? 10'd0 : high;
    count_eff  = begin_req ? '0 : byte_count;
    count_wide = 32'(count_eff);

    mode_next   = mode_eff;
    digits_next = digits_eff;
    accum_next  = accum_eff;
    high_next   = high_eff;
    hex         = hex_val(in_byte);
    code        = {accum_eff[11:0], hex[3:0]};
    enc         = 1'b0;
    cp          = 21'd0;
    p           = '0;
    p.kind      = KIND_BYTE;
    p.error_code = ERR_NONE;

    unique case (mode_eff)
      MODE_NORMAL: begin
        if (in_byte == 8'h22) begin
          p.n = 3'd1;
          p.kind = KIND_DONE;
          p.decoded_length = (count_wide > 32'hFFFF) ? 16'hFFFF : count_wide[15:0];
          mode_next = MODE_DONE;
        end else if (in_byte == 8'h5C) begin
          mode_next = MODE_ESC;
        end else if (in_byte == 8'h00) begin
          p.n = 3'd1; p.kind = KIND_ERROR; p.error_code = ERR_NO_QUOTE;
          mode_next = MODE_DONE;
        end else if (in_byte < 8'h20) begin
          p.n = 3'd1; p.kind = KIND_ERROR; p.error_code = ERR_CONTROL;
          mode_next = MODE_DONE;
        end else begin
          p.n = 3'd1; p.bytes[0] = in_byte;
        end
      end
      MODE_ESC: begin
        mode_next = MODE_NORMAL;
        p.n = 3'd1;
        case (in_byte)
          8'h22, 8'h5C, 8'h2F: p.bytes[0] = in_byte;
          8'h62: p.bytes[0] = 8'h08;
          8'h66: p.bytes[0] = 8'h0C;
          8'h6E: p.bytes[0] = 8'h0A;
          8'h72: p.bytes[0] = 8'h0D;
          8'h74: p.bytes[0] = 8'h09;
          8'h75: begin
            p.n = 3'd0;
            mode_next = MODE_HEX1;
            digits_next = 2'd0;
            accum_next = 16'd0;
          end
          default: begin
            p.kind = KIND_ERROR; p.error_code = ERR_ESCAPE;
            mode_next = MODE_DONE;
          end
        endcase
      end
      MODE_HEX1, MODE_HEX2: begin
        if (!hex[4]) begin
          p.n = 3'd1; p.kind = KIND_ERROR; p.error_code = ERR_HEX;
          mode_next = MODE_DONE;
        end else begin
          accum_next = code;
          if (digits_eff != 2'd3) begin
            digits_next = digits_eff + 2'd1;
          end else begin
            digits_next = 2'd0;
            if (mode_eff == MODE_HEX1) begin
              if (code >= 16'hD800 && code <= 16'hDBFF) begin
                high_next = code[9:0];
                mode_next = MODE_WANT_BS;
              end else begin
                enc = 1'b1;
                cp = 21'(code);
                mode_next = MODE_NORMAL;
              end
            end else if (code < 16'hDC00 || code > 16'hDFFF) begin
              p.n = 3'd1; p.kind = KIND_ERROR; p.error_code = ERR_SURROGATE;
              mode_next = MODE_DONE;
            end else begin
              enc = 1'b1;
              cp = 21'({high_eff, code[9:0]}) + 21'h10000;
              mode_next = MODE_NORMAL;
            end
          end
        end
      end
      MODE_WANT_BS: begin
        if (in_byte == 8'h5C) begin
          mode_next = MODE_WANT_U;
        end else begin
          p.n = 3'd1; p.kind = KIND_ERROR; p.error_code = ERR_SURROGATE;
          mode_next = MODE_DONE;
        end
      end
      MODE_WANT_U: begin
        if (in_byte == 8'h75) begin
          mode_next = MODE_HEX2;
          digits_next = 2'd0;
          accum_next = 16'd0;
        end else begin
          p.n = 3'd1; p.kind = KIND_ERROR; p.error_code = ERR_SURROGATE;
          mode_next = MODE_DONE;
        end
      end
      default: mode_next = MODE_DONE;
    endcase

    if (enc) begin
      if (cp <= 21'h7F) begin
        p.n = 3'd1;
        p.bytes[0] = cp[7:0];
      end else if (cp <= 21'h7FF) begin
        p.n = 3'd2;
        p.bytes[0] = {3'b110, cp[10:6]};
        p.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp <= 21'hFFFF) begin
        p.n = 3'd3;
        p.bytes[0] = {4'b1110, cp[15:12]};
        p.bytes[1] = {2'b10, cp[11:6]};
        p.bytes[2] = {2'b10, cp[5:0]};
      end else begin
        p.n = 3'd4;
        p.bytes[0] = {5'b11110, cp[20:18]};
        p.bytes[1] = {2'b10, cp[17:12]};
        p.bytes[2] = {2'b10, cp[11:6]};
        p.bytes[3] = {2'b10, cp[5:0]};
      end
    end

    // saturating length count; at most four bytes per beat
    count_sum = {1'b0, count_eff} + (LENGTH_BITS + 1)'(p.n);
    if (p.kind != KIND_BYTE) count_next = count_eff;
    else if (count_sum[LENGTH_BITS]) count_next = '1;
    else count_next = count_sum[LENGTH_BITS-1:0];
  end

  assign pkt       = p;
  assign pkt_valid = take && (p.n != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_NORMAL;
      digits     <= 2'd0;
      accum      <= 16'd0;
      high       <= 10'd0;
      byte_count <= '0;
    end else if (take) begin
      mode       <= mode_next;
      digits     <= digits_next;
      accum      <= accum_next;
      high       <= high_next;
      byte_count <= count_next;
    end
  end

endmodule

// ===== rtl/jsu_fifo.sv =====
// Short queue of decoded packets between front and back ends.
module jsu_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  jsu_pkg::jsu_pkt_t wdata,
  output logic              full,
  input  logic              rd,
  output jsu_pkg::jsu_pkt_t rdata,
  output logic              empty
);
  import jsu_pkg::*;

  localparam int PW = $clog2(PKT_DEPTH);

  jsu_pkt_t      slots [PKT_DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [PW:0]   fill;

  assign full  = (fill == (PW + 1)'(PKT_DEPTH));
  assign empty = (fill == '0);
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr && !full) slots[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (wr && !full) wptr <= wptr + 1'b1;
      if (rd && !empty) rptr <= rptr + 1'b1;
      case ({wr && !full, rd && !empty})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/jsu_back.sv =====
// Back end: splits packets into single results behind an output register.
module jsu_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  jsu_pkg::jsu_pkt_t q_data,
  output logic              q_rd,
  output logic [7:0]        out_byte,
  output logic [1:0]        kind,
  output logic [2:0]        error_code,
  output logic [15:0]       decoded_length,
  output logic              last,
  output logic              empty,
  input  logic              pop
);
  import jsu_pkg::*;

  jsu_pkt_t   cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       out_valid;
  logic       load, cur_last;

  assign cur_last = ({1'b0, idx} + 3'd1) == cur.n;
  assign load     = cur_valid && (!out_valid || pop);
  assign q_rd     = !q_empty && (!cur_valid || (load && cur_last));
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (q_rd) begin
        cur_valid <= 1'b1;
        idx       <= 2'd0;
      end else if (load && cur_last) begin
        cur_valid <= 1'b0;
      end else if (load) begin
        idx <= idx + 2'd1;
      end
      if (load) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) cur <= q_data;
    if (load) begin
      out_byte       <= cur.bytes[idx];
      kind           <= cur.kind;
      error_code     <= cur.error_code;
      decoded_length <= cur.decoded_length;
      last           <= cur_last;
    end
  end

endmodule

// ===== rtl/json_string_unescape_utf8.sv =====
// Top level of the JSON string unescaper with UTF-8 output.
//
//   channel  | handshake    | beat
//   ---------+--------------+------------------------------------------------
//   input    | push / full  | in_byte, begin_req
//   result   | pop / empty  | out_byte, kind, error_code, decoded_length, last
//
// One input byte is taken per cycle while the packet queue has room; the front
// end decodes it in the same cycle. Results leave at one per cycle while pop is high,
// so a beat that yields up to four UTF-8 bytes holds the back end until all have left.
// Input stalls when the four-entry packet queue fills, behind a stalled pop or
// behind multi-byte beats arriving faster than one result a cycle drains them.
// Synchronous reset empties the queue and returns the decoder to plain text.
module json_string_unescape_utf8 #(
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  in_byte,
  input  logic        begin_req,
  input  logic        push,
  output logic        full,
  output logic [7:0]  out_byte,
  output logic [1:0]  kind,
  output logic [2:0]  error_code,
  output logic [15:0] decoded_length,
  output logic        last,
  output logic        empty,
  input  logic        pop
);
  import jsu_pkg::*;

  jsu_pkt_t f_pkt, q_data;
  logic     f_valid, q_empty, q_rd, take;

  assign take = push && !full;

  jsu_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .in_byte  (in_byte),
    .begin_req(begin_req),
    .pkt_valid(f_valid),
    .pkt      (f_pkt)
  );

  jsu_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .wr   (f_valid),
    .wdata(f_pkt),
    .full (full),
    .rd   (q_rd),
    .rdata(q_data),
    .empty(q_empty)
  );

  jsu_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_data        (q_data),
    .q_rd          (q_rd),
    .out_byte      (out_byte),
    .kind          (kind),
    .error_code    (error_code),
    .decoded_length(decoded_length),
    .last          (last),
    .empty         (empty),
    .pop           (pop)
  );

endmodule

// ===== verif/tb.sv =====
// Self-checking bench for the JSON string unescaper: random strings, escapes, errors, stalls.
`timescale 1ns / 100ps

module tb;
  import jsu_pkg::*;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam int RANDOM_ITEMS     = 270;
  // worst case: every beat held behind a sparse pop pattern, plus sender gaps
  localparam int CYCLE_LIMIT      = 200_000;

  typedef enum logic [2:0] {
    ST_TEXT, ST_ESC, ST_HEX_HI, ST_WANT_BSL, ST_WANT_U, ST_HEX_LO, ST_DONE
  } esc_state_t;

  typedef struct packed {
    logic [7:0]  data;
    logic [1:0]  kind;
    logic [2:0]  code;
    logic [15:0] len;
    logic        last;
  } utf8_beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       bgn;
    logic       hold;
  } str_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [7:0]  in_byte = 8'h00;
  logic        begin_req = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic        full;
  logic [7:0]  out_byte;
  logic [1:0]  kind;
  logic [2:0]  error_code;
  logic [15:0] decoded_length;
  logic        last;
  logic        empty;

  json_string_unescape_utf8 dut (
    .clk            (clk),
    .rst            (rst),
    .in_byte        (in_byte),
    .begin_req      (begin_req),
    .push           (push),
    .full           (full),
    .out_byte       (out_byte),
    .kind           (kind),
    .error_code     (error_code),
    .decoded_length (decoded_length),
    .last           (last),
    .empty          (empty),
    .pop            (pop)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  esc_state_t  dec_mode;
  logic [1:0]  hex_cnt;
  logic [15:0] code_acc;
  logic [9:0]  hi_half;
  logic [15:0] byte_cnt;
  logic        err_seen;

  utf8_beat_t  due_beats[$];
  int          n_predicted = 0;
  int          n_checked = 0;
  int          n_accepted = 0;
  int          n_closed = 0;
  int          n_flagged = 0;
  int          n_mismatch = 0;

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    return -1;
  endfunction

  task automatic push_beat(input logic [7:0] d, input logic [1:0] k, input logic [2:0] c,
                           input logic [15:0] len);
    utf8_beat_t b;
    b.data = d;
    b.kind = k;
    b.code = c;
    b.len  = len;
    b.last = 1'b0;
    due_beats.push_back(b);
    n_predicted++;
  endtask

  task automatic put_data(input logic [7:0] d);
    push_beat(d, KIND_BYTE, ERR_NONE, 16'h0000);
    if (byte_cnt != 16'hFFFF) byte_cnt++;
  endtask

  task automatic raise(input logic [2:0] c);
    push_beat(8'h00, KIND_ERROR, c, 16'h0000);
    n_flagged++;
    err_seen = 1'b1;
    dec_mode = ST_DONE;
  endtask

  task automatic put_utf8(input logic [20:0] u);
    if (u <= 21'h7F) begin
      put_data(u[7:0]);
    end else if (u <= 21'h7FF) begin
      put_data({3'b110, u[10:6]});
      put_data({2'b10, u[5:0]});
    end else if (u <= 21'hFFFF) begin
      put_data({4'b1110, u[15:12]});
      put_data({2'b10, u[11:6]});
      put_data({2'b10, u[5:0]});
    end else begin
      put_data({5'b11110, u[20:18]});
      put_data({2'b10, u[17:12]});
      put_data({2'b10, u[11:6]});
      put_data({2'b10, u[5:0]});
    end
  endtask

  task automatic unescape_byte(input logic [7:0] b, input logic bgn);
    int         n0;
    int         h;
    utf8_beat_t tail;
    n0 = due_beats.size();
    if (bgn) begin
      dec_mode = ST_TEXT;
      hex_cnt  = 2'd0;
      code_acc = 16'h0000;
      hi_half  = 10'h000;
      byte_cnt = 16'h0000;
      err_seen = 1'b0;
    end
    if (dec_mode == ST_DONE || err_seen) return;
    case (dec_mode)
      ST_TEXT: begin
        if (b == CH_QUOTE) begin
          push_beat(8'h00, KIND_DONE, ERR_NONE, byte_cnt);
          n_closed++;
          dec_mode = ST_DONE;
        end else if (b == CH_BSL) begin
          dec_mode = ST_ESC;
        end else if (b == CH_NUL) begin
          raise(ERR_NO_QUOTE);
        end else if (b < 8'h20) begin
          raise(ERR_CONTROL);
        end else begin
          put_data(b);
        end
      end
      ST_ESC: begin
        dec_mode = ST_TEXT;
        case (b)
          CH_QUOTE, CH_BSL, "/": put_data(b);
          "b": put_data(8'h08);
          "f": put_data(8'h0C);
          "n": put_data(8'h0A);
          "r": put_data(8'h0D);
          "t": put_data(8'h09);
          CH_U: begin
            dec_mode = ST_HEX_HI;
            hex_cnt  = 2'd0;
            code_acc = 16'h0000;
          end
          default: raise(ERR_ESCAPE);
        endcase
      end
      ST_HEX_HI, ST_HEX_LO: begin
        h = hex_nibble(b);
        if (h < 0) begin
          raise(ERR_HEX);
        end else begin
          code_acc = {code_acc[11:0], 4'(h)};
          if (hex_cnt != 2'd3) begin
            hex_cnt++;
          end else begin
            hex_cnt = 2'd0;
            if (dec_mode == ST_HEX_HI) begin
              if (code_acc >= 16'hD800 && code_acc <= 16'hDBFF) begin
                hi_half  = code_acc[9:0];
                dec_mode = ST_WANT_BSL;
              end else begin
                put_utf8({5'd0, code_acc});
                dec_mode = ST_TEXT;
              end
            end else if (code_acc < 16'hDC00 || code_acc > 16'hDFFF) begin
              raise(ERR_SURROGATE);
            end else begin
              put_utf8(21'h10000 + {1'b0, hi_half, code_acc[9:0]});
              dec_mode = ST_TEXT;
            end
          end
        end
      end
      ST_WANT_BSL: begin
        if (b == CH_BSL) dec_mode = ST_WANT_U;
        else raise(ERR_SURROGATE);
      end
      ST_WANT_U: begin
        if (b == CH_U) begin
          dec_mode = ST_HEX_LO;
          hex_cnt  = 2'd0;
          code_acc = 16'h0000;
        end else begin
          raise(ERR_SURROGATE);
        end
      end
      default: dec_mode = ST_DONE;
    endcase
    if (due_beats.size() > n0) begin
      tail = due_beats.pop_back();
      tail.last = 1'b1;
      due_beats.push_back(tail);
    end
  endtask

  // ---------------------------------------------------------------- stimulus
  str_item_t str_bytes[$];
  logic      new_string = 1'b0;
  logic      hold_next = 1'b0;

  task automatic add(input logic [7:0] d);
    str_item_t it;
    it.data = d;
    it.bgn  = new_string;
    it.hold = hold_next;
    str_bytes.push_back(it);
    new_string = 1'b0;
    hold_next  = 1'b0;
  endtask

  function automatic logic [7:0] escape_letter(input int i);
    case (i)
      0: return CH_QUOTE;
      1: return CH_BSL;
      2: return "/";
      3: return "b";
      4: return "f";
      5: return "n";
      6: return "r";
      default: return "t";
    endcase
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
    if (nib < 4'd10) return "0" + 8'(nib);
    return (upper ? "A" : "a") + 8'(nib) - 8'd10;
  endfunction

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    do c = 8'($urandom_range(8'h20, 8'hFF)); while (c == CH_QUOTE || c == CH_BSL);
    return c;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (hex_nibble(c) >= 0);
    return c;
  endfunction

  task automatic add_u_escape(input logic [15:0] v);
    add(CH_BSL);
    add(CH_U);
    for (int k = 3; k >= 0; k--) add(hex_char(v[k*4 +: 4], bit'($urandom_range(0, 1))));
  endtask

  task automatic add_high();
    add_u_escape(16'hD800 + 16'($urandom_range(0, 16'h3FF)));
  endtask

  task automatic add_random_code();
    logic [15:0] v;
    case ($urandom_range(0, 3))
      0: case ($urandom_range(0, 5))
           0: v = 16'h0000;
           1: v = 16'h007F;
           2: v = 16'h0080;
           3: v = 16'h07FF;
           4: v = 16'h0800;
           default: v = 16'hFFFF;
         endcase
      1: v = 16'($urandom_range(0, 16'h7FF));
      default: v = 16'($urandom_range(0, 16'hFFFF));
    endcase
    add_u_escape(v);
    if (v >= 16'hD800 && v <= 16'hDBFF)
      add_u_escape(16'hDC00 + 16'($urandom_range(0, 16'h3FF)));
  endtask

  task automatic add_bad_tail();
    logic [7:0] c;
    int         pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: add(CH_NUL);
      1: add(8'($urandom_range(1, 8'h1F)));
      2: begin
        // any byte after a backslash that is not a known escape letter
        do c = 8'($urandom_range(0, 255));
        while (c == CH_U || c == escape_letter(0) || c == escape_letter(1) ||
               c == escape_letter(2) || c == escape_letter(3) || c == escape_letter(4) ||
               c == escape_letter(5) || c == escape_letter(6) || c == escape_letter(7));
        add(CH_BSL);
        add(c);
      end
      3: begin
        add(CH_BSL);
        add(CH_NUL);
      end
      4: begin
        add(CH_BSL);
        add(CH_U);
        repeat ($urandom_range(0, 3)) add(hex_char(4'($urandom_range(0, 15)), 1'b1));
        add(non_hex_char());
      end
      5: begin
        add_high();
        do c = 8'($urandom_range(0, 255)); while (c == CH_BSL);
        add(c);
      end
      6: begin
        add_high();
        add(CH_BSL);
        do c = 8'($urandom_range(0, 255)); while (c == CH_U);
        add(c);
      end
      7: begin
        add_high();
        if ($urandom_range(0, 1) == 0) add_u_escape(16'($urandom_range(0, 16'hDBFF)));
        else add_u_escape(16'($urandom_range(16'hE000, 16'hFFFF)));
      end
      8: begin
        add_high();
        add(CH_BSL);
        add(CH_U);
        repeat ($urandom_range(0, 3)) add(hex_char(4'($urandom_range(0, 15)), 1'b0));
        add(non_hex_char());
      end
      default: begin
        add_high();
        add(CH_NUL);
      end
    endcase
  endtask

  task automatic add_random_string();
    int pick;
    new_string = 1'b1;
    repeat ($urandom_range(0, 8)) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        add(text_char());
      end else if (pick < 60) begin
        add(CH_BSL);
        add(escape_letter($urandom_range(0, 7)));
      end else if (pick < 75) begin
        add_random_code();
      end else if (pick < 85) begin
        add_high();
        add_u_escape(16'hDC00 + 16'($urandom_range(0, 16'h3FF)));
      end else if (pick < 90) begin
        add_u_escape(16'hDC00 + 16'($urandom_range(0, 16'h3FF)));
      end else begin
        add(text_char());
      end
    end
    if ($urandom_range(0, 99) < 78) add(CH_QUOTE);
    else add_bad_tail();
    // trailing junk after the string has finished, sometimes opening a new string
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        new_string = ($urandom_range(0, 5) == 0);
        add(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // ---------------------------------------------------------------- driver
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    str_item_t it;
    if (rst) begin
      push <= 1'b0;
      burst_left = $urandom_range(1, 48);
      gap_left = 0;
    end else begin
      if (push && !full) begin
        unescape_byte(in_byte, begin_req);
        n_accepted++;
      end
      if (!push || !full) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (str_bytes.size() == 0 ||
                     (str_bytes[0].hold && n_predicted != n_checked)) begin
          push <= 1'b0;
        end else begin
          it = str_bytes.pop_front();
          in_byte   <= it.data;
          begin_req <= it.bgn;
          push      <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  logic [15:0] pop_mask = 16'hFFFF;
  int          pop_phase = 0;
  int          mask_age = 0;

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      n_mismatch++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    utf8_beat_t want;
    if (!rst && pop && !empty) begin
      if (due_beats.size() == 0) begin
        n_mismatch++;
        $display("%0t ns: unexpected beat, expected none, actual kind %0d byte %0h",
                 $time, kind, out_byte);
      end else begin
        want = due_beats.pop_front();
        check_field("out_byte", 16'(want.data), 16'(out_byte));
        check_field("kind", 16'(want.kind), 16'(kind));
        check_field("error_code", 16'(want.code), 16'(error_code));
        check_field("decoded_length", want.len, decoded_length);
        check_field("last", 16'(want.last), 16'(last));
        n_checked <= n_checked + 1;
      end
    end
    mask_age++;
    if (mask_age >= 300) begin
      mask_age = 0;
      case ($urandom_range(0, 3))
        0: pop_mask = 16'hFFFF;
        1: pop_mask = 16'($urandom);
        2: pop_mask = 16'($urandom) & 16'($urandom);
        default: pop_mask = 16'($urandom) | 16'($urandom);
      endcase
      if (pop_mask == 16'h0000) pop_mask = 16'h0001;
    end
    pop_phase = (pop_phase + 1) % 16;
    pop <= pop_mask[pop_phase];
  end

  // ---------------------------------------------------------------- watchdog
  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still outstanding",
               cycle_count, n_predicted - n_checked);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    dec_mode = ST_TEXT;
    hex_cnt  = 2'd0;
    code_acc = 16'h0000;
    hi_half  = 10'h000;
    byte_cnt = 16'h0000;
    err_seen = 1'b0;

    // plain extremes, a simple escape, close, then a byte after finish
    new_string = 1'b1;
    add(8'h20);
    add(8'hFF);
    add(CH_BSL);
    add("t");
    add(CH_QUOTE);
    add("x");
    // zero byte in text, then junk while latched
    new_string = 1'b1;
    add(CH_NUL);
    add(8'h01);
    // control byte
    new_string = 1'b1;
    add(8'h1F);
    // surrogate pair giving a four-byte sequence
    new_string = 1'b1;
    add_u_escape(16'hD800);
    add(CH_BSL);
    add(CH_U);
    add("d");
    add("c");
    add("0");
    add("0");
    add(CH_QUOTE);
    // zero byte straight after a backslash
    new_string = 1'b1;
    add(CH_BSL);
    add(CH_NUL);

    hold_next = 1'b1;
    while (str_bytes.size() < RANDOM_ITEMS / 2) add_random_string();
    hold_next = 1'b1;
    while (str_bytes.size() < RANDOM_ITEMS) add_random_string();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (str_bytes.size() != 0 || push) @(posedge clk);
    while (n_checked != n_predicted) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("run covered %0d input beats and %0d result beats: %0d strings closed,",
             n_accepted, n_checked, n_closed);
    $display("%0d errors flagged, with bursty input and a stalling receiver", n_flagged);
    if (n_mismatch == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_fifo.sv
rtl/jsu_back.sv
rtl/json_string_unescape_utf8.sv
verif/tb.sv
